// File: rtl/core/mcp_pkg.sv
// Shared types, character codes and helper functions for the motor command line parser.
// No dependencies; imported by every module of the block.

package mcp_pkg;

    // Default longest line, counting the slot that is never stored.
    localparam int LINE_CHARS_DEFAULT = 100;

    // Character codes used by the line matcher.
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Command word lengths.
    localparam int RIGHT_LEN       = 7;
    localparam int LEFT_LEN        = 8;
    localparam int DUTY_PREFIX_LEN = 4;

    // Decimal accumulator saturates just above the largest legal duty.
    localparam logic [6:0] NUMBER_SAT = 7'd101;
    localparam logic [6:0] DUTY_MAX   = 7'd100;

    // floor(d*255/100) = floor(d*51/20), done as d*51*3277 >> 16 (exact for d <= 100).
    localparam logic [24:0] COMPARE_SCALE = 25'd167127;

    // Result status codes.
    localparam logic [2:0] STATUS_RIGHT    = 3'd0;
    localparam logic [2:0] STATUS_LEFT     = 3'd1;
    localparam logic [2:0] STATUS_DUTY_SET = 3'd2;
    localparam logic [2:0] STATUS_DUTY_BAD = 3'd3;
    localparam logic [2:0] STATUS_UNKNOWN  = 3'd4;

    // Verdict of the parser for the byte held in the input register.
    typedef struct packed {
        logic       has_result;
        logic [2:0] status;
        logic [6:0] duty;
        logic       enable_a;
        logic       enable_b;
    } cmd_result_t;

    // Letters of the word that selects the right channel.
    function automatic logic [7:0] right_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h44; // D
            3'd1:    ch = 8'h49; // I
            3'd2:    ch = 8'h52; // R
            3'd3:    ch = 8'h45; // E
            3'd4:    ch = 8'h49; // I
            3'd5:    ch = 8'h54; // T
            3'd6:    ch = 8'h41; // A
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Letters of the word that selects the left channel.
    function automatic logic [7:0] left_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h45; // E
            3'd1:    ch = 8'h53; // S
            3'd2:    ch = 8'h51; // Q
            3'd3:    ch = 8'h55; // U
            3'd4:    ch = 8'h45; // E
            3'd5:    ch = 8'h52; // R
            3'd6:    ch = 8'h44; // D
            3'd7:    ch = 8'h41; // A
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Letters of the duty command prefix.
    function automatic logic [7:0] duty_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h44; // D
            2'd1:    ch = 8'h55; // U
            2'd2:    ch = 8'h54; // T
            2'd3:    ch = 8'h59; // Y
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // PWM compare level for a duty in percent.
    function automatic logic [7:0] compare_of(input logic [6:0] duty);
        logic [24:0] product;
        product = {18'b0, duty} * COMPARE_SCALE;
        return product[23:16];
    endfunction

endpackage

// File: rtl/core/mcp_parser.sv
// Per-line match state and command judgment for the motor command line parser.
// Depends on mcp_pkg for character codes, command words and the result struct.

module mcp_parser #(
    parameter int LINE_CHARS = mcp_pkg::LINE_CHARS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           byte_in,
    output mcp_pkg::cmd_result_t result
);
    import mcp_pkg::*;

    localparam int LEN_W = $clog2(LINE_CHARS);

    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic [LEN_W-1:0] text_len_reg, text_len_next;
    logic             text_ended_reg, text_ended_next;
    logic             right_match_reg, right_match_next;
    logic             left_match_reg, left_match_next;
    logic             duty_match_reg, duty_match_next;
    logic             past_spaces_reg, past_spaces_next;
    logic             digits_valid_reg, digits_valid_next;
    logic [6:0]       number_reg, number_next;
    logic [6:0]       duty_reg, duty_next;
    logic             enable_a_reg, enable_a_next;
    logic             enable_b_reg, enable_b_next;

    logic             end_of_line;
    logic [10:0]      number_acc;

    assign end_of_line = (byte_in == CHAR_LF) || (byte_in == CHAR_CR);

    // Decimal accumulate: number * 10 + digit.
    assign number_acc = ({4'b0, number_reg} << 3) + ({4'b0, number_reg} << 1)
                      + {7'b0, byte_in[3:0]};

    // Next line state and the verdict at a line end.
    always_comb
    begin
        line_len_next     = line_len_reg;
        text_len_next     = text_len_reg;
        text_ended_next   = text_ended_reg;
        right_match_next  = right_match_reg;
        left_match_next   = left_match_reg;
        duty_match_next   = duty_match_reg;
        past_spaces_next  = past_spaces_reg;
        digits_valid_next = digits_valid_reg;
        number_next       = number_reg;
        duty_next         = duty_reg;
        enable_a_next     = enable_a_reg;
        enable_b_next     = enable_b_reg;
        result            = '0;

        if (!end_of_line)
        begin
            // Bytes beyond the line limit are dropped.
            if (line_len_reg < LEN_W'(LINE_CHARS - 1))
            begin
                line_len_next = line_len_reg + 1'b1;
                if (!text_ended_reg)
                begin
                    if (byte_in == CHAR_NUL)
                    begin
                        text_ended_next = 1'b1;
                    end
                    else
                    begin
                        if (text_len_reg < LEN_W'(RIGHT_LEN))
                        begin
                            if (byte_in != right_char(text_len_reg[2:0]))
                            begin
                                right_match_next = 1'b0;
                            end
                        end
                        else
                        begin
                            right_match_next = 1'b0;
                        end

                        if (text_len_reg < LEN_W'(LEFT_LEN))
                        begin
                            if (byte_in != left_char(text_len_reg[2:0]))
                            begin
                                left_match_next = 1'b0;
                            end
                        end
                        else
                        begin
                            left_match_next = 1'b0;
                        end

                        // Duty prefix, then leading spaces, then digits only.
                        if (text_len_reg < LEN_W'(DUTY_PREFIX_LEN))
                        begin
                            if (byte_in != duty_char(text_len_reg[1:0]))
                            begin
                                duty_match_next = 1'b0;
                            end
                        end
                        else if (!((byte_in == CHAR_SPACE) && !past_spaces_reg))
                        begin
                            past_spaces_next = 1'b1;
                            if (byte_in inside {[CHAR_ZERO:CHAR_NINE]})
                            begin
                                number_next = (number_acc > {4'b0, NUMBER_SAT}) ?
                                              NUMBER_SAT : number_acc[6:0];
                            end
                            else
                            begin
                                digits_valid_next = 1'b0;
                            end
                        end

                        text_len_next = text_len_reg + 1'b1;
                    end
                end
            end
        end
        else
        begin
            // A line end judges the text, if any, and clears the line state.
            if (text_len_reg != '0)
            begin
                result.has_result = 1'b1;
                if (right_match_reg && (text_len_reg == LEN_W'(RIGHT_LEN)))
                begin
                    enable_a_next = 1'b1;
                    enable_b_next = 1'b0;
                    result.status = STATUS_RIGHT;
                end
                else if (left_match_reg && (text_len_reg == LEN_W'(LEFT_LEN)))
                begin
                    enable_a_next = 1'b0;
                    enable_b_next = 1'b1;
                    result.status = STATUS_LEFT;
                end
                else if (duty_match_reg && (text_len_reg >= LEN_W'(DUTY_PREFIX_LEN)))
                begin
                    if (digits_valid_reg && (number_reg <= DUTY_MAX))
                    begin
                        duty_next     = number_reg;
                        result.status = STATUS_DUTY_SET;
                    end
                    else
                    begin
                        result.status = STATUS_DUTY_BAD;
                    end
                end
                else
                begin
                    result.status = STATUS_UNKNOWN;
                end
            end
            line_len_next     = '0;
            text_len_next     = '0;
            text_ended_next   = 1'b0;
            right_match_next  = 1'b1;
            left_match_next   = 1'b1;
            duty_match_next   = 1'b1;
            past_spaces_next  = 1'b0;
            digits_valid_next = 1'b1;
            number_next       = '0;
        end

        result.duty     = duty_next;
        result.enable_a = enable_a_next;
        result.enable_b = enable_b_next;
    end

    // State advances only when the held byte moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg     <= '0;
            text_len_reg     <= '0;
            text_ended_reg   <= 1'b0;
            right_match_reg  <= 1'b1;
            left_match_reg   <= 1'b1;
            duty_match_reg   <= 1'b1;
            past_spaces_reg  <= 1'b0;
            digits_valid_reg <= 1'b1;
            number_reg       <= '0;
            duty_reg         <= '0;
            enable_a_reg     <= 1'b0;
            enable_b_reg     <= 1'b0;
        end
        else if (step)
        begin
            line_len_reg     <= line_len_next;
            text_len_reg     <= text_len_next;
            text_ended_reg   <= text_ended_next;
            right_match_reg  <= right_match_next;
            left_match_reg   <= left_match_next;
            duty_match_reg   <= duty_match_next;
            past_spaces_reg  <= past_spaces_next;
            digits_valid_reg <= digits_valid_next;
            number_reg       <= number_next;
            duty_reg         <= duty_next;
            enable_a_reg     <= enable_a_next;
            enable_b_reg     <= enable_b_next;
        end
    end

endmodule

// File: rtl/core/motor_command_line_parser.sv
// Motor command line parser: takes serial bytes, gives one result word per command line.
// Depends on mcp_pkg and mcp_parser.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per word.
//   CR or LF ends a line; a line with text gives one result word on the output
//   channel (out_valid/out_ready): status, duty_percent, compare_value and the
//   two channel enables. Lines without text give nothing.
//   A taken byte waits in the input register; its result goes to the result register.
//   Throughput: one byte per cycle while no line end with text waits on a stall,
//   set by the single input register feeding the match logic and the result register.
//   While a result word waits on a stalled output, bytes that make no result
//   keep flowing; the next line end with text waits in the input register and
//   holds in_ready low until the pending result is taken.
//   Reset clears the line state, the duty to 0 and both enables, and empties
//   the input and result registers.

module motor_command_line_parser #(
    parameter int LINE_CHARS = mcp_pkg::LINE_CHARS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [6:0] duty_percent,
    output logic [7:0] compare_value,
    output logic       channel_a_on,
    output logic       channel_b_on
);
    import mcp_pkg::*;

    logic        hold_valid_reg;
    logic [7:0]  hold_byte_reg;
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [6:0]  duty_reg;
    logic [7:0]  compare_reg;
    logic        chan_a_reg;
    logic        chan_b_reg;

    cmd_result_t result;
    logic        out_free;
    logic        hold_fire;

    mcp_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (hold_fire),
        .byte_in (hold_byte_reg),
        .result  (result)
    );

    // The held byte moves on unless it makes a result and the output is full.
    assign out_free  = !out_valid_reg || out_ready;
    assign hold_fire = hold_valid_reg && (!result.has_result || out_free);
    assign in_ready  = !hold_valid_reg || hold_fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hold_fire && result.has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_fire && result.has_result)
        begin
            status_reg  <= result.status;
            duty_reg    <= result.duty;
            compare_reg <= compare_of(result.duty);
            chan_a_reg  <= result.enable_a;
            chan_b_reg  <= result.enable_b;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign duty_percent  = duty_reg;
    assign compare_value = compare_reg;
    assign channel_a_on  = chan_a_reg;
    assign channel_b_on  = chan_b_reg;

endmodule

// File: rtl/core/mcp_checker.sv
// Port-level checks for the motor command line parser, bound to the top level.
// Depends on mcp_pkg for the status codes and on motor_command_line_parser.

module mcp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [6:0] duty_percent,
    input logic [7:0] compare_value,
    input logic       channel_a_on,
    input logic       channel_b_on
);
    import mcp_pkg::*;

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(duty_percent) && $stable(compare_value))
        else $error("stalled result word changed");

    // The two channels are never enabled together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(channel_a_on && channel_b_on))
        else $error("both channels enabled");

    // A direction command leaves exactly its own channel on.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_RIGHT) |-> channel_a_on && !channel_b_on)
        else $error("right command without channel A alone");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_LEFT) |-> channel_b_on && !channel_a_on)
        else $error("left command without channel B alone");

    // Duty stays in range and the compare level follows it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_MAX)
            && (compare_value == compare_of(duty_percent)))
        else $error("duty or compare level out of step");

endmodule

bind motor_command_line_parser mcp_checker u_mcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .duty_percent  (duty_percent),
    .compare_value (compare_value),
    .channel_a_on  (channel_a_on),
    .channel_b_on  (channel_b_on)
);

// File: dv/tb_top.sv
// Self-checking testbench for the motor command line parser: directed and random command lines.
// Depends on mcp_pkg and the motor_command_line_parser RTL, which needs mcp_parser.

module tb_top;
    import mcp_pkg::*;

    localparam int TOTAL_BYTES  = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // Command words packed first letter high, so letter p sits at bits [8*(len-1-p) +: 8].
    localparam logic [8*RIGHT_LEN-1:0]       RIGHT_WORD = "DIREITA";
    localparam logic [8*LEFT_LEN-1:0]        LEFT_WORD  = "ESQUERDA";
    localparam logic [8*DUTY_PREFIX_LEN-1:0] DUTY_WORD  = "DUTY";

    // One result word as the output channel shows it.
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] duty;
        logic [7:0] compare;
        logic       chan_a;
        logic       chan_b;
    } motor_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] status;
    logic [6:0] duty_percent;
    logic [7:0] compare_value;
    logic       channel_a_on;
    logic       channel_b_on;

    motor_command_line_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .duty_percent (duty_percent),
        .compare_value(compare_value),
        .channel_a_on (channel_a_on),
        .channel_b_on (channel_b_on)
    );

    always #5 clk = ~clk;

    // Bytes waiting to be sent and command results waiting to arrive.
    logic [7:0]    byte_q[$];
    motor_result_t result_q[$];

    // Tracked parser state, matching the block's reset values.
    logic [6:0] line_len    = '0;
    logic       text_done   = 1'b0;
    logic [6:0] text_len    = '0;
    logic       right_ok    = 1'b1;
    logic       left_ok     = 1'b1;
    logic       duty_ok     = 1'b1;
    logic       spaces_done = 1'b0;
    logic       digits_ok   = 1'b1;
    logic [6:0] num_val     = '0;
    logic [6:0] duty_now    = '0;
    logic       ena         = 1'b0;
    logic       enb         = 1'b0;

    int total_bytes = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int cycles = 0;
    int long_lines = 0;
    int status_count[5] = '{default: 0};
    int sender_idle_pct;
    int receiver_stall_pct;
    motor_result_t want;

    // Line state goes back to its reset value at every line end.
    task automatic clear_line();
        line_len    = '0;
        text_done   = 1'b0;
        text_len    = '0;
        right_ok    = 1'b1;
        left_ok     = 1'b1;
        duty_ok     = 1'b1;
        spaces_done = 1'b0;
        digits_ok   = 1'b1;
        num_val     = '0;
    endtask

    // Advance the tracked state by one accepted byte; queue a result at a line end with text.
    task automatic track_byte(input logic [7:0] c);
        motor_result_t res;
        int acc;
        if (c != CHAR_LF && c != CHAR_CR)
        begin
            if (line_len < LINE_CHARS_DEFAULT - 1)
            begin
                line_len = line_len + 7'd1;
                if (!text_done)
                begin
                    if (c == CHAR_NUL)
                    begin
                        text_done = 1'b1;
                    end
                    else
                    begin
                        if (text_len < RIGHT_LEN)
                        begin
                            if (c != RIGHT_WORD[8*(RIGHT_LEN-1-text_len) +: 8])
                                right_ok = 1'b0;
                        end
                        else
                        begin
                            right_ok = 1'b0;
                        end
                        if (text_len < LEFT_LEN)
                        begin
                            if (c != LEFT_WORD[8*(LEFT_LEN-1-text_len) +: 8])
                                left_ok = 1'b0;
                        end
                        else
                        begin
                            left_ok = 1'b0;
                        end
                        // After the prefix: skip leading spaces, then only digits may follow.
                        if (text_len < DUTY_PREFIX_LEN)
                        begin
                            if (c != DUTY_WORD[8*(DUTY_PREFIX_LEN-1-text_len) +: 8])
                                duty_ok = 1'b0;
                        end
                        else if (!(c == CHAR_SPACE && !spaces_done))
                        begin
                            spaces_done = 1'b1;
                            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                            begin
                                acc = int'(num_val) * 10 + int'(c - CHAR_ZERO);
                                num_val = (acc > int'(NUMBER_SAT)) ? NUMBER_SAT : acc[6:0];
                            end
                            else
                            begin
                                digits_ok = 1'b0;
                            end
                        end
                        text_len = text_len + 7'd1;
                    end
                end
            end
        end
        else if (text_len == 0)
        begin
            clear_line();
        end
        else
        begin
            if (right_ok && text_len == RIGHT_LEN)
            begin
                ena = 1'b1;
                enb = 1'b0;
                res.status = STATUS_RIGHT;
            end
            else if (left_ok && text_len == LEFT_LEN)
            begin
                enb = 1'b1;
                ena = 1'b0;
                res.status = STATUS_LEFT;
            end
            else if (duty_ok && text_len >= DUTY_PREFIX_LEN)
            begin
                if (digits_ok && num_val <= DUTY_MAX)
                begin
                    duty_now = num_val;
                    res.status = STATUS_DUTY_SET;
                end
                else
                begin
                    res.status = STATUS_DUTY_BAD;
                end
            end
            else
            begin
                res.status = STATUS_UNKNOWN;
            end
            clear_line();
            acc = int'(duty_now) * 255 / 100;
            res.duty    = duty_now;
            res.compare = acc[7:0];
            res.chan_a  = ena;
            res.chan_b  = enb;
            result_q.push_back(res);
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(s[i]);
    endtask

    task automatic push_line(input string s, input logic [7:0] term);
        push_text(s);
        byte_q.push_back(term);
    endtask

    task automatic push_spaces(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back(CHAR_SPACE);
    endtask

    // Any byte that does not end a line.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
    endfunction

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // One random line: mostly well-formed commands with random content, the rest broken or noise.
    task automatic push_random_line();
        string w;
        int kind;
        int k;
        int pos;
        int mode;
        kind = $urandom_range(0, 99);
        if (kind < 18)
        begin
            push_text("DIREITA");
        end
        else if (kind < 36)
        begin
            push_text("ESQUERDA");
        end
        else if (kind < 72)
        begin
            push_text("DUTY");
            push_spaces($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 4));
            k = $urandom_range(0, 99);
            if (k < 60)
                push_text($sformatf("%0d", $urandom_range(0, 100)));
            else if (k < 70)
                push_text($sformatf("%0d", $urandom_range(101, 99999)));
            else if (k < 76)
                ;
            else if (k < 84)
                push_text($sformatf("00%0d", $urandom_range(0, 120)));
            else if (k < 90)
                push_text($sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "+",
                                    $urandom_range(0, 100)));
            else
            begin
                push_text($sformatf("%0d", $urandom_range(0, 100)));
                byte_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : text_byte());
            end
        end
        else if (kind < 84)
        begin
            // Damaged command word: one letter changed, cut short, or one letter added.
            k = $urandom_range(0, 2);
            w = (k == 0) ? "DIREITA" : (k == 1) ? "ESQUERDA" : "DUTY";
            pos = $urandom_range(0, w.len() - 1);
            mode = $urandom_range(0, 2);
            for (int i = 0; i < w.len(); i++)
            begin
                if (mode == 0 && i == pos)
                    byte_q.push_back(text_byte());
                else if (!(mode == 1 && i >= pos))
                    byte_q.push_back(w[i]);
            end
            if (mode == 2)
                byte_q.push_back(text_byte());
        end
        else if (kind < 92)
        begin
            k = $urandom_range(1, 12);
            for (int i = 0; i < k; i++)
                byte_q.push_back(text_byte());
        end
        else if (kind < 96)
        begin
            // A NUL somewhere in or after a command ends the matched text.
            k = $urandom_range(0, 2);
            w = (k == 0) ? "DIREITA" : (k == 1) ? "ESQUERDA" : "DUTY 42";
            pos = $urandom_range(0, w.len());
            for (int i = 0; i < w.len(); i++)
            begin
                if (i == pos)
                    byte_q.push_back(CHAR_NUL);
                byte_q.push_back(w[i]);
            end
            if (pos == w.len())
                byte_q.push_back(CHAR_NUL);
            for (int i = $urandom_range(0, 3); i > 0; i--)
                byte_q.push_back(text_byte());
        end
        else if (kind < 98 || long_lines >= 4)
        begin
            // Empty line: nothing but the line end below.
        end
        else
        begin
            long_lines++;
            push_text("DUTY");
            push_spaces($urandom_range(90, 100));
            push_text("8");
            for (int i = $urandom_range(0, 20); i > 0; i--)
                byte_q.push_back(text_byte());
        end
        byte_q.push_back(line_end());
        if ($urandom_range(0, 99) < 15)
            byte_q.push_back(CHAR_LF);
    endtask

    // Idling mix per third of the run: receiver-heavy, sender-heavy, then none.
    always @*
    begin
        if (total_bytes == 0 || bytes_sent * 3 >= total_bytes * 2)
        begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
        end
        else if (bytes_sent * 3 < total_bytes)
        begin
            sender_idle_pct    = 19;
            receiver_stall_pct = 77;
        end
        else
        begin
            sender_idle_pct    = 77;
            receiver_stall_pct = 19;
        end
    end

    // Driver: feeds the byte queue into the input channel and tracks each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_byte(rx_byte);
                bytes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest pending result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: result with none pending, status %0d duty %0d",
                             $time, status, duty_percent);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("duty_percent", want.duty, duty_percent);
                    check_field("compare_value", want.compare, compare_value);
                    check_field("channel_a_on", want.chan_a, channel_a_on);
                    check_field("channel_b_on", want.chan_b, channel_b_on);
                    status_count[want.status]++;
                    results_seen++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Directed lines: each command, its edges, and the odd line shapes.
        push_line("DIREITA", CHAR_CR);
        push_line("ESQUERDA", CHAR_LF);
        push_line("DUTY 50", CHAR_LF);
        push_line("DUTY", CHAR_LF);
        push_line("DUTY100", CHAR_CR);
        push_line("DUTY   100", CHAR_LF);
        push_line("DUTY 101", CHAR_LF);
        push_line("DUTY 99999", CHAR_LF);
        push_line("DUTY -5", CHAR_LF);
        push_line("DUTY 5 ", CHAR_LF);
        push_line("DUTYX", CHAR_CR);
        push_line("DIREITAS", CHAR_LF);
        push_line("ESQUERD", CHAR_LF);
        push_line("dutY 5", CHAR_LF);
        push_line("", CHAR_CR);
        byte_q.push_back(CHAR_LF);
        byte_q.push_back(CHAR_NUL);
        push_line("DIREITA", CHAR_LF);
        push_text("DIREITA");
        byte_q.push_back(CHAR_NUL);
        push_line("xyz", CHAR_LF);
        push_text("DUTY 7");
        byte_q.push_back(CHAR_NUL);
        push_line("9", CHAR_CR);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);
        byte_q.push_back(8'h7F);
        byte_q.push_back(CHAR_LF);
        // Longest line: the last stored byte is a digit, the rest is dropped.
        push_text("DUTY");
        push_spaces(LINE_CHARS_DEFAULT - 6);
        push_line("7XYZ", CHAR_LF);
        // One byte longer, so the digit itself is dropped.
        push_text("DUTY");
        push_spaces(LINE_CHARS_DEFAULT - 5);
        push_line("7", CHAR_LF);
        push_line("ESQUERDA", CHAR_CR);
        push_line("DUTY 0", CHAR_LF);

        total_bytes = TOTAL_BYTES;
        while (byte_q.size() < total_bytes)
            push_random_line();
        total_bytes = byte_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes over %0d cycles; checked %0d command results.",
                 bytes_sent, cycles, results_seen);
        $display("Right %0d, left %0d, duty set %0d, duty invalid %0d, unknown %0d.",
                 status_count[STATUS_RIGHT], status_count[STATUS_LEFT],
                 status_count[STATUS_DUTY_SET], status_count[STATUS_DUTY_BAD],
                 status_count[STATUS_UNKNOWN]);
        if (errors == 0 && result_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
